// ===== rtl/core/max_frequency_stack_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the maximum-frequency stack
// Shared helpers; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef MAX_FREQUENCY_STACK_DEFINES_SVH
`define MAX_FREQUENCY_STACK_DEFINES_SVH

// condition holds at every clock edge out of reset
`define MFS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define MFS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mfs_pkg.sv =====
// ----------------------------------------------------------------------------
// mfs_pkg
// Operation and status codes of the maximum-frequency stack.
// ----------------------------------------------------------------------------
`default_nettype none

package mfs_pkg;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [1:0] ST_PUSH_OK   = 2'd0;
  localparam logic [1:0] ST_POP_OK    = 2'd1;
  localparam logic [1:0] ST_POP_EMPTY = 2'd2;
  localparam logic [1:0] ST_PUSH_FULL = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/core/mfs_ram.sv =====
// ----------------------------------------------------------------------------
// mfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/max_frequency_stack.sv =====
// ----------------------------------------------------------------------------
// max_frequency_stack
// Stack that pops the most frequent value, newest first on ties.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one request per item, in_operation
//   0 pushes in_value, 1 pops the most frequent stored value.
//   Result channel (out_valid / out_stall): one result per request, carrying
//   out_popped_value (zero unless a pop succeeded) and out_status.
//   A push runs through states PU1, PU2 and PU3 to its result, a pop through
//   PO1 to PO4, and a full push or an empty pop through ERR. Requests are
//   taken only in IDLE, one at a time, as set by the chain of dependent reads
//   through the count, level-head, node and free-slot RAMs.
//   After reset the count RAM is swept to zero, one entry a cycle, over
//   all 2**VALUE_BITS entries, with in_stall held high. The level-head and
//   free-slot RAMs need no sweep: watermarks mark untouched entries.
//   A result waits in the output register while out_stall is high; the
//   final commit of the next request waits for that register to free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "max_frequency_stack_defines.svh"

module max_frequency_stack #(
  parameter int VALUE_BITS = 10,
  parameter int CAPACITY   = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_operation,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [VALUE_BITS-1:0] out_popped_value,
  output logic      [1:0]            out_status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int NV = 1 << VALUE_BITS;
  localparam logic [PW-1:0] NULL_PTR = PW'(CAPACITY);
  localparam logic [PW-1:0] CAP_P    = PW'(CAPACITY);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_PU1  = 4'd2;
  localparam logic [3:0] S_PU2  = 4'd3;
  localparam logic [3:0] S_PU3  = 4'd4;
  localparam logic [3:0] S_PO1  = 4'd5;
  localparam logic [3:0] S_PO2  = 4'd6;
  localparam logic [3:0] S_PO3  = 4'd7;
  localparam logic [3:0] S_PO4  = 4'd8;
  localparam logic [3:0] S_ERR  = 4'd9;

  logic [3:0]            state_r, state_nxt;
  logic [VALUE_BITS-1:0] clr_idx_r, clr_idx_nxt;
  logic [PW-1:0]         ft_r, ft_nxt;
  logic [PW-1:0]         hl_r, hl_nxt;
  logic [PW-1:0]         min_total_r, min_total_nxt;
  logic [PW-1:0]         max_level_r, max_level_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [PW-1:0]         cnt_r, cnt_nxt;
  logic [AW-1:0]         slot_r, slot_nxt;
  logic [AW-1:0]         node_r, node_nxt;
  logic [PW-1:0]         below_r, below_nxt;
  logic [VALUE_BITS-1:0] pval_r, pval_nxt;
  logic [1:0]            err_st_r, err_st_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_pval_r, out_pval_nxt;
  logic [1:0]            out_st_r, out_st_nxt;

  // RAM ports
  logic                       cnt_we;
  logic [VALUE_BITS-1:0]      cnt_waddr, cnt_raddr;
  logic [PW-1:0]              cnt_wdata, cnt_rdata;
  logic                       top_we;
  logic [AW-1:0]              top_waddr, top_raddr;
  logic [PW-1:0]              top_wdata, top_rdata;
  logic                       ent_we;
  logic [AW-1:0]              ent_waddr, ent_raddr;
  logic [VALUE_BITS+PW-1:0]   ent_wdata, ent_rdata;
  logic                       fre_we;
  logic [AW-1:0]              fre_waddr, fre_raddr;
  logic [AW-1:0]              fre_wdata, fre_rdata;

  logic                  in_accept;
  logic                  load_ok;
  logic [PW-1:0]         ft_dec;
  logic [PW-1:0]         hl_dec;
  logic [PW-1:0]         lvl;
  logic [PW-1:0]         top_eff;
  logic [VALUE_BITS-1:0] ent_val;
  logic [PW-1:0]         ent_below;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign load_ok   = !out_valid_r || !out_stall;
  assign ft_dec    = ft_r - PW'(1);
  assign hl_dec    = hl_r - PW'(1);
  assign lvl       = cnt_r + PW'(1);
  assign ent_val   = ent_rdata[VALUE_BITS+PW-1:PW];
  assign ent_below = ent_rdata[PW-1:0];
  // level heads above the highest level ever reached were never written
  assign top_eff   = (cnt_r < max_level_r) ? top_rdata : NULL_PTR;

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_pval_r;
  assign out_status       = out_st_r;

  // read addresses
  always_comb begin
    cnt_raddr = val_r;
    if (state_r == S_PO3) begin
      cnt_raddr = ent_val;
    end else if (state_r == S_PO4) begin
      cnt_raddr = pval_r;
    end
    top_raddr = (state_r == S_PU2) ? cnt_rdata[AW-1:0]
              : (state_r == S_PU3) ? cnt_r[AW-1:0]
              : hl_dec[AW-1:0];
    ent_raddr = (state_r == S_PO2) ? top_rdata[AW-1:0] : node_r;
    fre_raddr = ft_dec[AW-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    ft_nxt        = ft_r;
    hl_nxt        = hl_r;
    min_total_nxt = min_total_r;
    max_level_nxt = max_level_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    slot_nxt      = slot_r;
    node_nxt      = node_r;
    below_nxt     = below_r;
    pval_nxt      = pval_r;
    err_st_nxt    = err_st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_pval_nxt  = out_pval_r;
    out_st_nxt    = out_st_r;

    cnt_we    = 1'b0;
    cnt_waddr = val_r;
    cnt_wdata = lvl;
    top_we    = 1'b0;
    top_waddr = cnt_r[AW-1:0];
    top_wdata = PW'(slot_r);
    ent_we    = 1'b0;
    ent_waddr = slot_r;
    ent_wdata = {val_r, top_eff};
    fre_we    = 1'b0;
    fre_waddr = ft_r[AW-1:0];
    fre_wdata = node_r;

    unique case (state_r)
      S_CLR: begin
        cnt_we      = 1'b1;
        cnt_waddr   = clr_idx_r;
        cnt_wdata   = '0;
        clr_idx_nxt = clr_idx_r + VALUE_BITS'(1);
        if (clr_idx_r == VALUE_BITS'(NV - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          val_nxt = in_value;
          if (in_operation == mfs_pkg::OP_PUSH) begin
            if (ft_r == '0) begin
              err_st_nxt = mfs_pkg::ST_PUSH_FULL;
              state_nxt  = S_ERR;
            end else begin
              state_nxt = S_PU1;
            end
          end else begin
            if (hl_r == '0) begin
              err_st_nxt = mfs_pkg::ST_POP_EMPTY;
              state_nxt  = S_ERR;
            end else begin
              state_nxt = S_PO1;
            end
          end
        end
      end
      S_PU1: begin
        state_nxt = S_PU2;
      end
      S_PU2: begin
        cnt_nxt = cnt_rdata;
        // free-slot entries below the low watermark still hold their own index
        slot_nxt  = (ft_dec < min_total_r) ? ft_dec[AW-1:0] : fre_rdata;
        state_nxt = S_PU3;
      end
      S_PU3: begin
        if (load_ok) begin
          cnt_we = 1'b1;
          top_we = 1'b1;
          ent_we = 1'b1;
          ft_nxt = ft_dec;
          if (ft_dec < min_total_r) begin
            min_total_nxt = ft_dec;
          end
          if (lvl > hl_r) begin
            hl_nxt = lvl;
          end
          if (lvl > max_level_r) begin
            max_level_nxt = lvl;
          end
          out_valid_nxt = 1'b1;
          out_pval_nxt  = '0;
          out_st_nxt    = mfs_pkg::ST_PUSH_OK;
          state_nxt     = S_IDLE;
        end
      end
      S_PO1: begin
        state_nxt = S_PO2;
      end
      S_PO2: begin
        node_nxt  = top_rdata[AW-1:0];
        state_nxt = S_PO3;
      end
      S_PO3: begin
        pval_nxt  = ent_val;
        below_nxt = ent_below;
        state_nxt = S_PO4;
      end
      S_PO4: begin
        if (load_ok) begin
          cnt_we    = 1'b1;
          cnt_waddr = pval_r;
          cnt_wdata = (cnt_rdata != '0) ? cnt_rdata - PW'(1) : cnt_rdata;
          top_we    = 1'b1;
          top_waddr = hl_dec[AW-1:0];
          top_wdata = below_r;
          fre_we    = 1'b1;
          ft_nxt    = ft_r + PW'(1);
          if (below_r == NULL_PTR) begin
            hl_nxt = hl_dec;
          end
          out_valid_nxt = 1'b1;
          out_pval_nxt  = pval_r;
          out_st_nxt    = mfs_pkg::ST_POP_OK;
          state_nxt     = S_IDLE;
        end
      end
      S_ERR: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_pval_nxt  = '0;
          out_st_nxt    = err_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      ft_r        <= CAP_P;
      hl_r        <= '0;
      min_total_r <= CAP_P;
      max_level_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      ft_r        <= ft_nxt;
      hl_r        <= hl_nxt;
      min_total_r <= min_total_nxt;
      max_level_r <= max_level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    cnt_r      <= cnt_nxt;
    slot_r     <= slot_nxt;
    node_r     <= node_nxt;
    below_r    <= below_nxt;
    pval_r     <= pval_nxt;
    err_st_r   <= err_st_nxt;
    out_pval_r <= out_pval_nxt;
    out_st_r   <= out_st_nxt;
  end

  mfs_ram #(.WIDTH(PW), .DEPTH(NV)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  mfs_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_top_ram (
    .clk   (clk),
    .we    (top_we),
    .waddr (top_waddr),
    .wdata (top_wdata),
    .raddr (top_raddr),
    .rdata (top_rdata)
  );

  mfs_ram #(.WIDTH(VALUE_BITS + PW), .DEPTH(CAPACITY)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  mfs_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free_ram (
    .clk   (clk),
    .we    (fre_we),
    .waddr (fre_waddr),
    .wdata (fre_wdata),
    .raddr (fre_raddr),
    .rdata (fre_rdata)
  );

  `MFS_ASSERT_ALWAYS(a_level_watermark, hl_r <= max_level_r, "highest level above watermark")
  `MFS_ASSERT_ALWAYS(a_free_watermark, min_total_r <= ft_r, "free count below low watermark")
  `MFS_ASSERT_IMPLY(a_empty_pool, ft_r == CAP_P, hl_r == '0, "all slots free but levels present")
  `MFS_ASSERT_IMPLY(a_result_source, $rose(out_valid_r),
    $past(state_r) == S_PU3 || $past(state_r) == S_PO4 || $past(state_r) == S_ERR,
    "result raised outside a commit state")

endmodule

`default_nettype wire
